// File: hw/rtl/pir_pkg.sv
`default_nettype none

package pir_pkg;

  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned OUT_WIDTH   = 64;
  localparam int unsigned RADIX_W     = 6;
  localparam int unsigned CHAR_W      = 8;

  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_BIN   = 6'd2;
  localparam logic [RADIX_W-1:0] LIMIT_OCT   = 6'd25;
  localparam logic [RADIX_W-1:0] LIMIT_HEX   = 6'd34;
  localparam logic [RADIX_W-1:0] LIMIT_BIN   = 6'd12;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_7     = 8'h37;
  localparam logic [CHAR_W-1:0] CH_8     = 8'h38;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LC_O  = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_UC_O  = 8'h4F;
  localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LC_B  = 8'h62;
  localparam logic [CHAR_W-1:0] CH_UC_B  = 8'h42;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NBSP  = 8'hA0;

  typedef enum logic [5:0] {
    PH_SKIP   = 6'b000001,
    PH_START  = 6'b000010,
    PH_ZERO   = 6'b000100,
    PH_DIGITS = 6'b001000,
    PH_AUTO   = 6'b010000,
    PH_ERROR  = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_RADIX = 2'd2,
    ST_CONFLICT  = 2'd3
  } status_e;

  typedef struct packed {
    logic               ok;
    logic [RADIX_W-1:0] val;
  } digit_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return c inside {CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE, CH_NBSP};
  endfunction

  function automatic digit_t digit_of(input logic [CHAR_W-1:0] c);
    digit_t d;
    d.ok  = 1'b1;
    d.val = '0;
    if (c inside {[CH_0:CH_9]}) begin
      d.val = RADIX_W'(c - CH_0);
    end else if (c inside {[CH_LC_A:CH_LC_Z]}) begin
      d.val = RADIX_W'(c - CH_LC_A) + RADIX_DEC;
    end else if (c inside {[CH_UC_A:CH_UC_Z]}) begin
      d.val = RADIX_W'(c - CH_UC_A) + RADIX_DEC;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/parse_integer_with_radix.sv
// Integer parser for a byte stream of text with optional radix prefix.
// Input: s_axis carries one character per transaction in tdata[7:0]; a NUL
// byte ends the string. Leading whitespace and one sign are skipped, a
// leading 0 may carry an o, x or b prefix.
// Output: m_axis carries one result per string: tdata[63:0] is the signed
// value, tuser[1:0] the status (ok, empty, radix above 36, prefix conflict).
// Configuration: cfg_we_i writes cfg_wdata_i into the forced radix register
// (0 autodetects); write it only between strings.
// Timing: one character per cycle is taken while s_axis_tready is high. The
// result of a string is registered and appears in m_axis in the cycle after
// its NUL is accepted.
// Stall: the result is held in the output register until taken; s_axis stays
// ready while that register is empty or being drained in the same cycle.
// Reset: clears the string state, the forced radix to 0 and the output valid.
`default_nettype none

module parse_integer_with_radix (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [5:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [63:0] value (signed)
  output logic [1:0]       m_axis_tuser    // [1:0] status
);

  localparam int unsigned VW = pir_pkg::VALUE_WIDTH;
  localparam int unsigned RW = pir_pkg::RADIX_W;

  logic [RW-1:0]    force_q;
  pir_pkg::phase_e  phase_q, phase_d;
  logic             neg_q, neg_d;
  logic [RW-1:0]    radix_q, radix_d;
  logic [VW-1:0]    main_q, main_d;
  logic [VW-1:0]    oct_q, oct_d;
  logic             main_stop_q, main_stop_d;
  logic             oct_stop_q, oct_stop_d;
  logic             hint_q, hint_d;
  logic             scan_q, scan_d;
  logic             used_q, used_d;
  pir_pkg::status_e pend_q, pend_d;

  logic             out_valid_q, out_valid_d;
  logic [63:0]      out_value_q, out_value_d;
  pir_pkg::status_e out_status_q, out_status_d;

  logic             accept;
  logic             is_nul;
  logic [7:0]       ch;
  pir_pkg::digit_t  dig;
  logic [RW-1:0]    step_radix;
  logic [VW-1:0]    mul_full;
  logic [VW-1:0]    md_value;
  logic             md_ok;
  logic             is_prefix;
  logic [RW-1:0]    pre_own;
  logic [RW-1:0]    pre_limit;
  logic             scan_in;
  logic [VW-1:0]    res_v;
  pir_pkg::status_e res_st;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign ch            = s_axis_tdata;
  assign is_nul        = (ch == pir_pkg::CH_NUL);
  assign dig           = pir_pkg::digit_of(ch);

  always_comb begin
    if (phase_q == pir_pkg::PH_SKIP || phase_q == pir_pkg::PH_START) begin
      step_radix = (force_q != '0) ? force_q : pir_pkg::RADIX_DEC;
    end else if (phase_q == pir_pkg::PH_ZERO) begin
      step_radix = (radix_q != '0) ? radix_q : pir_pkg::RADIX_DEC;
    end else begin
      step_radix = radix_q;
    end
  end

  assign mul_full = main_q * VW'(step_radix);
  assign md_value = mul_full + VW'(dig.val);
  assign md_ok    = dig.ok && (dig.val < step_radix);
  assign scan_in  = (phase_q == pir_pkg::PH_ZERO) || scan_q;

  always_comb begin
    is_prefix = 1'b1;
    pre_own   = pir_pkg::RADIX_OCT;
    pre_limit = pir_pkg::LIMIT_OCT;
    case (ch)
      pir_pkg::CH_LC_O, pir_pkg::CH_UC_O: begin
        pre_own   = pir_pkg::RADIX_OCT;
        pre_limit = pir_pkg::LIMIT_OCT;
      end
      pir_pkg::CH_LC_X, pir_pkg::CH_UC_X: begin
        pre_own   = pir_pkg::RADIX_HEX;
        pre_limit = pir_pkg::LIMIT_HEX;
      end
      pir_pkg::CH_LC_B, pir_pkg::CH_UC_B: begin
        pre_own   = pir_pkg::RADIX_BIN;
        pre_limit = pir_pkg::LIMIT_BIN;
      end
      default: is_prefix = 1'b0;
    endcase
  end

  always_comb begin
    res_v  = '0;
    res_st = pir_pkg::ST_OK;
    case (phase_q)
      pir_pkg::PH_SKIP, pir_pkg::PH_START: begin
        res_st = (force_q > pir_pkg::RADIX_MAX) ? pir_pkg::ST_BAD_RADIX : pir_pkg::ST_EMPTY;
      end
      pir_pkg::PH_ZERO: res_st = pir_pkg::ST_OK;
      pir_pkg::PH_DIGITS: begin
        res_v  = main_q;
        res_st = used_q ? pir_pkg::ST_OK : pir_pkg::ST_EMPTY;
      end
      pir_pkg::PH_AUTO: begin
        res_v  = hint_q ? main_q : oct_q;
        res_st = pir_pkg::ST_OK;
      end
      default: res_st = pend_q;
    endcase
    if (res_st == pir_pkg::ST_BAD_RADIX || res_st == pir_pkg::ST_CONFLICT) begin
      res_v = '0;
    end else if (neg_q) begin
      res_v = VW'(0) - res_v;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    neg_d       = neg_q;
    radix_d     = radix_q;
    main_d      = main_q;
    oct_d       = oct_q;
    main_stop_d = main_stop_q;
    oct_stop_d  = oct_stop_q;
    hint_d      = hint_q;
    scan_d      = scan_q;
    used_d      = used_q;
    pend_d      = pend_q;

    if (accept && !is_nul) begin
      case (phase_q)
        pir_pkg::PH_SKIP, pir_pkg::PH_START: begin
          if (phase_q == pir_pkg::PH_SKIP && pir_pkg::is_space(ch)) begin
            phase_d = phase_q;
          end else if (phase_q == pir_pkg::PH_SKIP && ch == pir_pkg::CH_MINUS) begin
            neg_d   = 1'b1;
            phase_d = pir_pkg::PH_START;
          end else if (phase_q == pir_pkg::PH_SKIP && ch == pir_pkg::CH_PLUS) begin
            phase_d = pir_pkg::PH_START;
          end else if (force_q > pir_pkg::RADIX_MAX) begin
            pend_d  = pir_pkg::ST_BAD_RADIX;
            phase_d = pir_pkg::PH_ERROR;
          end else if (ch == pir_pkg::CH_0) begin
            used_d  = 1'b1;
            radix_d = force_q;
            phase_d = pir_pkg::PH_ZERO;
          end else begin
            radix_d = step_radix;
            phase_d = pir_pkg::PH_DIGITS;
            if (md_ok) begin
              main_d = md_value;
              used_d = 1'b1;
            end else begin
              main_stop_d = 1'b1;
            end
          end
        end
        pir_pkg::PH_ZERO: begin
          if (is_prefix) begin
            if (radix_q != '0 && radix_q != pre_own && radix_q < pre_limit) begin
              pend_d  = pir_pkg::ST_CONFLICT;
              phase_d = pir_pkg::PH_ERROR;
            end else begin
              radix_d = (radix_q != '0) ? radix_q : pre_own;
              used_d  = 1'b1;
              phase_d = pir_pkg::PH_DIGITS;
            end
          end else begin
            radix_d = step_radix;
            phase_d = (radix_q != '0) ? pir_pkg::PH_DIGITS : pir_pkg::PH_AUTO;
            if (radix_q == '0) begin
              hint_d = hint_q || (ch == pir_pkg::CH_DOT || ch == pir_pkg::CH_8 ||
                                  ch == pir_pkg::CH_9);
              scan_d = ch inside {[pir_pkg::CH_0:pir_pkg::CH_9], pir_pkg::CH_DOT};
              if (ch inside {[pir_pkg::CH_0:pir_pkg::CH_7]}) begin
                oct_d = {oct_q[VW-4:0], ch[2:0]};
              end else begin
                oct_stop_d = 1'b1;
              end
            end
            if (md_ok) begin
              main_d = md_value;
              used_d = 1'b1;
            end else begin
              main_stop_d = 1'b1;
            end
          end
        end
        pir_pkg::PH_DIGITS, pir_pkg::PH_AUTO: begin
          if (phase_q == pir_pkg::PH_AUTO) begin
            hint_d = hint_q || (scan_in && (ch == pir_pkg::CH_DOT || ch == pir_pkg::CH_8 ||
                                            ch == pir_pkg::CH_9));
            scan_d = scan_in && (ch inside {[pir_pkg::CH_0:pir_pkg::CH_9], pir_pkg::CH_DOT});
            if (!oct_stop_q) begin
              if (ch inside {[pir_pkg::CH_0:pir_pkg::CH_7]}) begin
                oct_d = {oct_q[VW-4:0], ch[2:0]};
              end else begin
                oct_stop_d = 1'b1;
              end
            end
          end
          if (!main_stop_q) begin
            if (md_ok) begin
              main_d = md_value;
              used_d = 1'b1;
            end else begin
              main_stop_d = 1'b1;
            end
          end
        end
        default: phase_d = phase_q;
      endcase
    end else if (accept) begin
      phase_d     = pir_pkg::PH_SKIP;
      neg_d       = 1'b0;
      radix_d     = pir_pkg::RADIX_DEC;
      main_d      = '0;
      oct_d       = '0;
      main_stop_d = 1'b0;
      oct_stop_d  = 1'b0;
      hint_d      = 1'b0;
      scan_d      = 1'b0;
      used_d      = 1'b0;
      pend_d      = pir_pkg::ST_OK;
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    if (accept && is_nul) begin
      out_valid_d  = 1'b1;
      out_value_d  = 64'(signed'(res_v));
      out_status_d = res_st;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_q     <= '0;
      phase_q     <= pir_pkg::PH_SKIP;
      neg_q       <= 1'b0;
      radix_q     <= pir_pkg::RADIX_DEC;
      main_q      <= '0;
      oct_q       <= '0;
      main_stop_q <= 1'b0;
      oct_stop_q  <= 1'b0;
      hint_q      <= 1'b0;
      scan_q      <= 1'b0;
      used_q      <= 1'b0;
      pend_q      <= pir_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        force_q <= cfg_wdata_i;
      end
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      radix_q     <= radix_d;
      main_q      <= main_d;
      oct_q       <= oct_d;
      main_stop_q <= main_stop_d;
      oct_stop_q  <= oct_stop_d;
      hint_q      <= hint_d;
      scan_q      <= scan_d;
      used_q      <= used_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;

`ifndef NO_ASSERTIONS
  a_nul_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_nul |=> m_axis_tvalid)
    else $error("result missing after string end");

  a_char_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_nul && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result raised without string end");

  a_error_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == pir_pkg::ST_BAD_RADIX ||
                      m_axis_tuser == pir_pkg::ST_CONFLICT) |-> m_axis_tdata == '0)
    else $error("nonzero value with error status");

  a_string_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_nul |=> phase_q == pir_pkg::PH_SKIP && !neg_q && !used_q)
    else $error("string state not cleared after result");
`endif

endmodule

`default_nettype wire
